>>> rtl/assert_macros.svh
// include guard
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SFTA_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("strip/fan assembler: same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define SFTA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("strip/fan assembler: next-cycle check failed");

`endif

>>> rtl/sfta_pkg.sv
package sfta_pkg;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam logic REG_VERTEX_LIMIT = 1'b0;
    localparam logic REG_TRIANGLE_CAP = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_CORNER = 2'd0;
    localparam logic [1:0] STATUS_END    = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    // parser phase
    typedef enum logic [1:0] {
        PH_COMMAND,
        PH_RECORDS,
        PH_DONE
    } phase_t;

    // kind of work handed to the back end
    typedef enum logic [1:0] {
        JOB_TRIANGLE,
        JOB_END,
        JOB_BAD
    } job_kind_t;

    // one vertex record as held by the parser
    typedef struct packed {
        logic [15:0] idx;
        logic [15:0] s;
        logic [15:0] t;
    } rec_t;

    // one corner of a triangle job
    typedef struct packed {
        logic [14:0] idx;
        logic [15:0] s;
        logic [15:0] t;
    } corner_t;

    // one queue entry: a triangle or a status result
    typedef struct packed {
        job_kind_t    kind;
        corner_t [2:0] corners;
        logic [15:0]  count;
    } job_t;

endpackage

>>> rtl/sfta_front.sv
module sfta_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [15:0]       word,
    input  logic              mesh_start,
    input  logic [14:0]       vertex_limit,
    input  logic [15:0]       triangle_cap,
    output logic              push,
    output sfta_pkg::job_t    push_job
);

    // index check: non-negative and below the vertex limit
    function automatic logic index_ok(input logic [15:0] idx, input logic [14:0] limit);
        index_ok = !idx[15] && (idx[14:0] < limit);
    endfunction

    sfta_pkg::phase_t phase_reg, phase_next;
    logic             fan_reg, fan_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      pos_reg, pos_next;
    logic [1:0]       wir_reg, wir_next;
    logic [15:0]      emitted_reg, emitted_next;
    logic [15:0]      cur_idx_reg, cur_idx_next;
    logic [15:0]      cur_s_reg, cur_s_next;
    sfta_pkg::rec_t   pivot_reg, pivot_next;
    sfta_pkg::rec_t   prev0_reg, prev0_next;
    sfta_pkg::rec_t   prev1_reg, prev1_next;

    // state as seen by this word, after a mesh start clear
    sfta_pkg::phase_t phase_eff;
    logic [15:0]      pos_eff;
    logic [1:0]       wir_eff;
    logic [15:0]      emitted_eff;

    logic             in_command;
    logic             in_records;
    logic             end_cmd;
    logic             rec_done;
    logic             tri_try;
    logic             bad;
    sfta_pkg::rec_t   new_rec;
    sfta_pkg::rec_t   c0;
    sfta_pkg::rec_t   c1;

    assign phase_eff   = mesh_start ? sfta_pkg::PH_COMMAND : phase_reg;
    assign pos_eff     = mesh_start ? 16'd0 : pos_reg;
    assign wir_eff     = mesh_start ? 2'd0 : wir_reg;
    assign emitted_eff = mesh_start ? 16'd0 : emitted_reg;

    assign in_command = accept && (phase_eff == sfta_pkg::PH_COMMAND);
    assign in_records = accept && (phase_eff == sfta_pkg::PH_RECORDS);
    assign end_cmd    = in_command && (word == 16'd0);
    assign rec_done   = in_records && (wir_eff == 2'd3);

    // record completed by this word
    assign new_rec = '{idx: cur_idx_reg, s: cur_s_reg, t: word};

    // corner order: fan pivots on the first vertex, strips alternate winding
    always_comb
    begin
        if (fan_reg)
        begin
            c0 = pivot_reg;
            c1 = prev0_reg;
        end
        else if (!pos_eff[0])
        begin
            c0 = prev1_reg;
            c1 = prev0_reg;
        end
        else
        begin
            c0 = prev0_reg;
            c1 = prev1_reg;
        end
    end

    assign tri_try = rec_done && (pos_eff[15:1] != 15'd0) && (emitted_eff < triangle_cap);
    assign bad     = tri_try && !(index_ok(c0.idx, vertex_limit)
                                  && index_ok(c1.idx, vertex_limit)
                                  && index_ok(new_rec.idx, vertex_limit));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_eff)
                sfta_pkg::PH_COMMAND:
                    phase_next = end_cmd ? sfta_pkg::PH_DONE : sfta_pkg::PH_RECORDS;
                sfta_pkg::PH_RECORDS:
                begin
                    priority if (bad)
                        phase_next = sfta_pkg::PH_DONE;
                    else if (rec_done && (left_reg == 16'd1))
                        phase_next = sfta_pkg::PH_COMMAND;
                    else
                        phase_next = sfta_pkg::PH_RECORDS;
                end
                default:
                    phase_next = sfta_pkg::PH_DONE;
            endcase
        end
    end

    // datapath and job output
    always_comb
    begin
        fan_next     = fan_reg;
        left_next    = left_reg;
        pos_next     = accept ? pos_eff : pos_reg;
        wir_next     = accept ? wir_eff : wir_reg;
        emitted_next = accept ? emitted_eff : emitted_reg;
        cur_idx_next = cur_idx_reg;
        cur_s_next   = cur_s_reg;
        pivot_next   = pivot_reg;
        prev0_next   = prev0_reg;
        prev1_next   = prev1_reg;

        push                = 1'b0;
        push_job.kind       = sfta_pkg::JOB_TRIANGLE;
        push_job.corners[0] = '{idx: c0.idx[14:0], s: c0.s, t: c0.t};
        push_job.corners[1] = '{idx: c1.idx[14:0], s: c1.s, t: c1.t};
        push_job.corners[2] = '{idx: new_rec.idx[14:0], s: new_rec.s, t: new_rec.t};
        push_job.count      = emitted_eff + 16'd1;

        // command word: end of mesh or a new run
        if (in_command)
        begin
            if (end_cmd)
            begin
                push           = 1'b1;
                push_job.kind  = sfta_pkg::JOB_END;
                push_job.count = emitted_eff;
            end
            else
            begin
                fan_next  = word[15];
                left_next = word[15] ? (~word + 16'd1) : word;
                pos_next  = 16'd0;
                wir_next  = 2'd0;
            end
        end

        // record words
        if (in_records)
        begin
            wir_next = wir_eff + 2'd1;
            unique case (wir_eff)
                2'd0:    cur_idx_next = word;
                2'd1:    ;
                2'd2:    cur_s_next   = word;
                default: ;
            endcase
            if (rec_done)
            begin
                if (pos_eff == 16'd0)
                    pivot_next = new_rec;
                if (bad)
                begin
                    push           = 1'b1;
                    push_job.kind  = sfta_pkg::JOB_BAD;
                    push_job.count = emitted_eff;
                end
                else
                begin
                    if (tri_try)
                    begin
                        push         = 1'b1;
                        emitted_next = emitted_eff + 16'd1;
                    end
                    prev1_next = prev0_reg;
                    prev0_next = new_rec;
                    pos_next   = pos_eff + 16'd1;
                    left_next  = left_reg - 16'd1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sfta_pkg::PH_COMMAND;
            fan_reg     <= 1'b0;
            left_reg    <= 16'd0;
            pos_reg     <= 16'd0;
            wir_reg     <= 2'd0;
            emitted_reg <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fan_reg     <= fan_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            wir_reg     <= wir_next;
            emitted_reg <= emitted_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        cur_s_reg   <= cur_s_next;
        pivot_reg   <= pivot_next;
        prev0_reg   <= prev0_next;
        prev1_reg   <= prev1_next;
    end

endmodule

>>> rtl/sfta_queue.sv
module sfta_queue
#(
    parameter int DEPTH = sfta_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfta_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output sfta_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfta_pkg::job_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/sfta_back.sv
module sfta_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  sfta_pkg::job_t     head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [14:0]        vertex_index,
    output logic signed [15:0] tex_s,
    output logic signed [15:0] tex_t,
    output logic [1:0]         corner,
    output logic               last_corner,
    output logic [15:0]        triangle_count
);

    logic        valid_reg, valid_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  status_reg, status_next;
    logic [14:0] idx_reg, idx_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] t_reg, t_next;
    logic [1:0]  corner_reg, corner_next;
    logic        last_reg, last_next;
    logic [15:0] count_reg, count_next;
    logic        load;
    sfta_pkg::corner_t sel;

    // output register free, or its result is being taken
    assign load = head_valid && (!valid_reg || out_ready);
    assign sel  = head_job.corners[cnt_reg];

    // unroll one job into its results
    always_comb
    begin
        valid_next  = valid_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        corner_next = corner_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        pop         = 1'b0;

        if (out_ready)
            valid_next = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            count_next = head_job.count;
            unique case (head_job.kind)
                sfta_pkg::JOB_TRIANGLE:
                begin
                    status_next = sfta_pkg::STATUS_CORNER;
                    idx_next    = sel.idx;
                    s_next      = sel.s;
                    t_next      = sel.t;
                    corner_next = cnt_reg;
                    last_next   = (cnt_reg == 2'd2);
                    pop         = (cnt_reg == 2'd2);
                    cnt_next    = (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                end
                sfta_pkg::JOB_END, sfta_pkg::JOB_BAD:
                begin
                    status_next = (head_job.kind == sfta_pkg::JOB_END)
                                  ? sfta_pkg::STATUS_END : sfta_pkg::STATUS_BAD;
                    idx_next    = 15'd0;
                    s_next      = 16'd0;
                    t_next      = 16'd0;
                    corner_next = 2'd0;
                    last_next   = 1'b1;
                    pop         = 1'b1;
                    cnt_next    = 2'd0;
                end
                default:
                begin
                    pop      = 1'b1;
                    cnt_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        corner_reg <= corner_next;
        last_reg   <= last_next;
        count_reg  <= count_next;
    end

    assign out_valid      = valid_reg;
    assign status         = status_reg;
    assign vertex_index   = idx_reg;
    assign tex_s          = s_reg;
    assign tex_t          = t_reg;
    assign corner         = corner_reg;
    assign last_corner    = last_reg;
    assign triangle_count = count_reg;

endmodule

>>> rtl/strip_fan_triangle_assembler.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// input     | in        | in_valid / in_ready   | stream_word, mesh_start
// result    | out       | out_valid / out_ready | status, vertex_index, tex_s, tex_t,
//           |           |                       | corner, last_corner, triangle_count
// config    | in        | write_enable          | register_index, write_data
//
// one stream word is taken per cycle while in_ready is high; the parser works on it
// in that same cycle; a triangle's job is queued by its last record word, then loaded
// into the output register; three corners leave one per cycle while out_ready is high
// the job queue (QUEUE_DEPTH entries) lets parser and output stall independently;
// in_ready drops only while the queue is full
// reset clears parser state, queue pointers and output valid; no clearing pass
`include "assert_macros.svh"

module strip_fan_triangle_assembler
#(
    parameter int QUEUE_DEPTH = sfta_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] stream_word,
    input  logic               mesh_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [14:0]        vertex_index,
    output logic signed [15:0] tex_s,
    output logic signed [15:0] tex_t,
    output logic [1:0]         corner,
    output logic               last_corner,
    output logic [15:0]        triangle_count,
    input  logic               write_enable,
    input  logic               register_index,
    input  logic [15:0]        write_data
);

    logic [14:0]    vertex_limit_reg;
    logic [15:0]    triangle_cap_reg;
    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;
    sfta_pkg::job_t push_job;
    sfta_pkg::job_t head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_limit_reg <= 15'd0;
            triangle_cap_reg <= 16'd0;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                sfta_pkg::REG_VERTEX_LIMIT: vertex_limit_reg <= write_data[14:0];
                sfta_pkg::REG_TRIANGLE_CAP: triangle_cap_reg <= write_data;
                default: ;
            endcase
        end
    end

    // input transfer
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    sfta_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .word         (16'(stream_word)),
        .mesh_start   (mesh_start),
        .vertex_limit (vertex_limit_reg),
        .triangle_cap (triangle_cap_reg),
        .push         (push),
        .push_job     (push_job)
    );

    sfta_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfta_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .vertex_index   (vertex_index),
        .tex_s          (tex_s),
        .tex_t          (tex_t),
        .corner         (corner),
        .last_corner    (last_corner),
        .triangle_count (triangle_count)
    );

    // checks
    `SFTA_ASSERT_NEXT(a_corners_back_to_back, clk, rst_n,
        out_valid && out_ready && status == sfta_pkg::STATUS_CORNER && corner != 2'd2,
        out_valid && status == sfta_pkg::STATUS_CORNER && corner == $past(corner) + 2'd1)
    `SFTA_ASSERT_NOW(a_status_is_last, clk, rst_n,
        out_valid && status != sfta_pkg::STATUS_CORNER,
        last_corner && corner == 2'd0 && vertex_index == 15'd0)
    `SFTA_ASSERT_NOW(a_last_on_third_corner, clk, rst_n,
        out_valid && status == sfta_pkg::STATUS_CORNER,
        last_corner == (corner == 2'd2))

endmodule
